// ===== hw/rtl/dfe_pkg.sv =====
// dfe_pkg: constants, codes and shared types of the DMX channel fade engine.
// Used by the channel interfaces and by every module of the block.
// No dependencies.
package dfe_pkg;

   // block geometry
   localparam int UNIVERSES    = 4;
   localparam int CHANNELS     = 512;
   localparam int TICK_MS      = 23;

   // transaction field widths
   localparam int CMD_W        = 3;
   localparam int UNI_W        = 2;
   localparam int CHAN_W       = 10;
   localparam int VALUE_W      = 16;
   localparam int DUR_W        = 20;
   localparam int STATUS_W     = 2;
   localparam int CHUNK_W      = 6;
   localparam int BYTES_W      = 64;
   localparam int LEVEL_W      = 8;

   // storage
   localparam int IDX_W        = 9;
   localparam int ADDR_W       = UNI_W + IDX_W;
   localparam int DEPTH        = 2 ** ADDR_W;
   localparam int BYTE_SEL_W   = 3;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   // fade arithmetic widths
   localparam int PROD1_W      = LEVEL_W + DUR_W;
   localparam int DIFF_W       = LEVEL_W + 1;
   localparam int PROD2_W      = DIFF_W + DUR_W + 1;
   localparam int NUM_W        = PROD2_W + 1;
   localparam int QBIT_W       = 3;

   // command codes on the request channel
   localparam logic [CMD_W-1:0] CMD_SET      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FADE     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_BLACKOUT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FADE_ALL = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TICK     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;

   // status codes on the response channel
   localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INACTIVE = 2'd2;

   typedef enum logic [2:0] {
      OP_SET,
      OP_FADE,
      OP_BLACKOUT,
      OP_FADE_ALL,
      OP_TICK,
      OP_READ,
      OP_UNKNOWN
   } op_code_type;

   // classified command passed from front to back
   typedef struct packed {
      op_code_type        op;
      logic [UNI_W-1:0]   universe;
      logic               uni_ok;
      logic               chan_ok;
      logic [IDX_W-1:0]   index;
      logic [LEVEL_W-1:0] level;
      logic [DUR_W-1:0]   duration;
   } op_type;

   // one channel's stored word
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               active;
      logic [LEVEL_W-1:0] start;
      logic [LEVEL_W-1:0] target;
      logic [DUR_W-1:0]   elapsed;
      logic [DUR_W-1:0]   length;
   } entry_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_RMW_RD,
      S_RMW_WR,
      S_SW_RD,
      S_SW_WR,
      S_FR_RD,
      S_FR_DAT,
      S_MUL_A,
      S_MUL_B,
      S_SUM,
      S_DIV,
      S_FR_WR,
      S_EMIT,
      S_RESP
   } back_state_type;

endpackage

// ===== hw/rtl/dfe_chan_if.sv =====
// dfe_chan_if: valid/ready channel interfaces for requests and responses.
// Depends on dfe_pkg for field widths.
interface dfe_req_if;
   import dfe_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          command;
   logic [UNI_W-1:0]          universe;
   logic [CHAN_W-1:0]         channel;
   logic signed [VALUE_W-1:0] value;
   logic [DUR_W-1:0]          duration_ms;

   modport source (output valid, command, universe, channel, value, duration_ms,
                   input ready);
   modport sink   (input valid, command, universe, channel, value, duration_ms,
                   output ready);
endinterface

interface dfe_rsp_if;
   import dfe_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [UNI_W-1:0]    universe_res;
   logic [CHUNK_W-1:0]  chunk_index;
   logic [BYTES_W-1:0]  channel_bytes;
   logic                last;

   modport source (output valid, status, universe_res, chunk_index, channel_bytes, last,
                   input ready);
   modport sink   (input valid, status, universe_res, chunk_index, channel_bytes, last,
                   output ready);
endinterface

// ===== hw/rtl/dfe_front.sv =====
// dfe_front: accepts request transactions and classifies them into commands.
// Depends on dfe_pkg and dfe_req_if.
module dfe_front (
   dfe_req_if.sink         req_chan,
   input  logic            queue_full,
   output logic            op_push,
   output dfe_pkg::op_type op_data
);
   import dfe_pkg::*;

   assign req_chan.ready = !queue_full;
   assign op_push        = req_chan.valid && !queue_full;

   // decode and range checks
   always_comb begin
      unique case (req_chan.command)
         CMD_SET:      op_data.op = OP_SET;
         CMD_FADE:     op_data.op = OP_FADE;
         CMD_BLACKOUT: op_data.op = OP_BLACKOUT;
         CMD_FADE_ALL: op_data.op = OP_FADE_ALL;
         CMD_TICK:     op_data.op = OP_TICK;
         CMD_READ:     op_data.op = OP_READ;
         default:      op_data.op = OP_UNKNOWN;
      endcase
      op_data.universe = req_chan.universe;
      op_data.uni_ok   = {1'b0, req_chan.universe} < (UNI_W+1)'(UNIVERSES);
      op_data.chan_ok  = (req_chan.channel != '0)
                         && ({1'b0, req_chan.channel} <= (CHAN_W+1)'(CHANNELS));
      op_data.index    = IDX_W'(req_chan.channel - 1'b1);
      // clamp to 0..255
      if (req_chan.value[VALUE_W-1]) begin
         op_data.level = '0;
      end else if (req_chan.value[VALUE_W-2:LEVEL_W] != '0) begin
         op_data.level = '1;
      end else begin
         op_data.level = req_chan.value[LEVEL_W-1:0];
      end
      op_data.duration = req_chan.duration_ms;
   end

endmodule

// ===== hw/rtl/dfe_queue.sv =====
// dfe_queue: short command queue between the front and the back.
// Depends on dfe_pkg.
module dfe_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  dfe_pkg::op_type push_data,
   input  logic            pop,
   output dfe_pkg::op_type pop_data,
   output logic            full,
   output logic            empty
);
   import dfe_pkg::*;

   op_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full     = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/dfe_back.sv =====
// dfe_back: executes queued commands against the channel store and builds frames.
// Depends on dfe_pkg and dfe_rsp_if.
module dfe_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            op_valid,
   input  dfe_pkg::op_type op_data,
   output logic            op_pop,
   dfe_rsp_if.source       rsp_chan
);
   import dfe_pkg::*;

   // channel store
   entry_type              mem [DEPTH];
   entry_type              rd_data_ff;
   logic                   mem_we;
   entry_type              mem_wdata;

   back_state_type         state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [UNIVERSES-1:0]   slot_active_ff, slot_active_in;
   logic                   advance_ff, advance_in;
   logic                   live_ff, live_in;
   logic [STATUS_W-1:0]    resp_status_ff, resp_status_in;
   logic [UNI_W-1:0]       resp_uni_ff, resp_uni_in;
   logic [BYTES_W-1:0]     bytes_ff, bytes_in;

   // fade arithmetic
   logic [DUR_W-1:0]           e_ff, e_in;
   logic [PROD1_W-1:0]         p1_ff, p1_in;
   logic signed [PROD2_W-1:0]  p2_ff, p2_in;
   logic [NUM_W-2:0]           rem_ff, rem_in;
   logic [LEVEL_W-1:0]         q_ff, q_in;
   logic [QBIT_W-1:0]          bit_ff, bit_in;

   // output register
   logic                   out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]    out_status_ff, out_status_in;
   logic [UNI_W-1:0]       out_uni_ff, out_uni_in;
   logic [CHUNK_W-1:0]     out_chunk_ff, out_chunk_in;
   logic [BYTES_W-1:0]     out_bytes_ff, out_bytes_in;
   logic                   out_last_ff, out_last_in;

   logic                   can_emit;
   logic [IDX_W-1:0]       idx;
   logic [UNI_W-1:0]       sweep_slot;
   logic                   sweep_live;
   logic [DUR_W:0]         e_sum;
   logic signed [DIFF_W-1:0] diff;
   logic signed [NUM_W-1:0]  num;
   logic [NUM_W-2:0]       den_shift;

   assign can_emit   = !out_valid_ff || rsp_chan.ready;
   assign idx        = addr_ff[IDX_W-1:0];
   assign sweep_slot = addr_ff[ADDR_W-1:IDX_W];
   assign sweep_live = ({1'b0, sweep_slot} < (UNI_W+1)'(UNIVERSES))
                       && slot_active_ff[sweep_slot];
   assign e_sum      = {1'b0, rd_data_ff.elapsed} + (DUR_W+1)'(TICK_MS);
   assign diff       = $signed({1'b0, rd_data_ff.target}) - $signed({1'b0, rd_data_ff.start});
   assign num        = $signed({2'b00, p1_ff, 1'b0}) + $signed({p2_ff, 1'b0})
                       + $signed({(NUM_W-DUR_W)'(0), rd_data_ff.length});
   assign den_shift  = (NUM_W-1)'({rd_data_ff.length, 1'b0}) << bit_ff;

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.status        = out_status_ff;
   assign rsp_chan.universe_res  = out_uni_ff;
   assign rsp_chan.chunk_index   = out_chunk_ff;
   assign rsp_chan.channel_bytes = out_bytes_ff;
   assign rsp_chan.last          = out_last_ff;

   // sequencer: next state, store writes and responses
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      addr_in        = addr_ff;
      slot_active_in = slot_active_ff;
      advance_in     = advance_ff;
      live_in        = live_ff;
      resp_status_in = resp_status_ff;
      resp_uni_in    = resp_uni_ff;
      bytes_in       = bytes_ff;
      e_in           = e_ff;
      p1_in          = p1_ff;
      p2_in          = p2_ff;
      rem_in         = rem_ff;
      q_in           = q_ff;
      bit_in         = bit_ff;
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_status_in  = out_status_ff;
      out_uni_in     = out_uni_ff;
      out_chunk_in   = out_chunk_ff;
      out_bytes_in   = out_bytes_ff;
      out_last_in    = out_last_ff;
      op_pop         = 1'b0;
      mem_we         = 1'b0;
      mem_wdata      = rd_data_ff;

      unique case (state_ff)
         // zero the whole store after reset
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            addr_in   = addr_ff + 1'b1;
            if (addr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (op_valid) begin
               op_pop   = 1'b1;
               op_in    = op_data;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            resp_uni_in = op_ff.universe;
            unique case (op_ff.op)
               OP_SET, OP_FADE: begin
                  resp_status_in = ST_IGNORED;
                  state_in       = S_RESP;
                  if (op_ff.uni_ok) begin
                     slot_active_in[op_ff.universe] = 1'b1;
                     if (op_ff.chan_ok) begin
                        addr_in  = {op_ff.universe, op_ff.index};
                        state_in = S_RMW_RD;
                     end
                  end
               end
               OP_BLACKOUT, OP_FADE_ALL: begin
                  addr_in  = '0;
                  state_in = S_SW_RD;
               end
               OP_TICK: begin
                  addr_in    = {op_ff.universe, IDX_W'(0)};
                  advance_in = 1'b1;
                  live_in    = 1'b1;
                  state_in   = S_FR_RD;
                  if (!op_ff.uni_ok || !slot_active_ff[op_ff.universe]) begin
                     resp_status_in = ST_INACTIVE;
                     state_in       = S_RESP;
                  end
               end
               OP_READ: begin
                  addr_in    = {op_ff.universe, IDX_W'(0)};
                  advance_in = 1'b0;
                  live_in    = op_ff.uni_ok && slot_active_ff[op_ff.universe];
                  state_in   = S_FR_RD;
               end
               default: begin
                  resp_status_in = ST_IGNORED;
                  resp_uni_in    = '0;
                  state_in       = S_RESP;
               end
            endcase
         end
         // single channel set or fade start
         S_RMW_RD: begin
            state_in = S_RMW_WR;
         end
         S_RMW_WR: begin
            mem_we = 1'b1;
            if (op_ff.op == OP_SET || op_ff.duration == '0) begin
               mem_wdata        = '0;
               mem_wdata.level  = op_ff.level;
            end else begin
               mem_wdata.active  = 1'b1;
               mem_wdata.start   = rd_data_ff.level;
               mem_wdata.target  = op_ff.level;
               mem_wdata.elapsed = '0;
               mem_wdata.length  = op_ff.duration;
            end
            resp_status_in = ST_DONE;
            state_in       = S_RESP;
         end
         // blackout and fade-all sweep over every entry
         S_SW_RD: begin
            state_in = S_SW_WR;
         end
         S_SW_WR: begin
            if (sweep_live) begin
               if (op_ff.op == OP_BLACKOUT || op_ff.duration == '0) begin
                  mem_we    = 1'b1;
                  mem_wdata = '0;
               end else if (rd_data_ff.level != '0) begin
                  mem_we            = 1'b1;
                  mem_wdata.active  = 1'b1;
                  mem_wdata.start   = rd_data_ff.level;
                  mem_wdata.target  = '0;
                  mem_wdata.elapsed = '0;
                  mem_wdata.length  = op_ff.duration;
               end
            end
            addr_in  = addr_ff + 1'b1;
            state_in = S_SW_RD;
            if (addr_ff == '1) begin
               resp_status_in = ST_DONE;
               resp_uni_in    = '0;
               state_in       = S_RESP;
            end
         end
         // frame walk: read one channel
         S_FR_RD: begin
            state_in = S_FR_DAT;
         end
         S_FR_DAT: begin
            e_in = (e_sum > {1'b0, rd_data_ff.length}) ? rd_data_ff.length
                                                        : e_sum[DUR_W-1:0];
            if (advance_ff && rd_data_ff.active) begin
               state_in = S_MUL_A;
            end else begin
               bytes_in = {(live_ff ? rd_data_ff.level : LEVEL_W'(0)),
                           bytes_ff[BYTES_W-1:LEVEL_W]};
               addr_in  = addr_ff + 1'b1;
               state_in = S_FR_RD;
               if (idx[BYTE_SEL_W-1:0] == '1) begin
                  addr_in  = addr_ff;
                  state_in = S_EMIT;
               end
            end
         end
         // start * length
         S_MUL_A: begin
            p1_in    = rd_data_ff.start * rd_data_ff.length;
            state_in = S_MUL_B;
         end
         // (target - start) * elapsed
         S_MUL_B: begin
            p2_in    = diff * $signed({1'b0, e_ff});
            state_in = S_SUM;
         end
         S_SUM: begin
            rem_in   = num[NUM_W-2:0];
            q_in     = '0;
            bit_in   = '1;
            state_in = S_DIV;
         end
         // restoring division by twice the length, one quotient bit a cycle
         S_DIV: begin
            if (rem_ff >= den_shift) begin
               rem_in       = rem_ff - den_shift;
               q_in[bit_ff] = 1'b1;
            end
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               state_in = S_FR_WR;
            end
         end
         S_FR_WR: begin
            mem_we            = 1'b1;
            mem_wdata.level   = q_ff;
            mem_wdata.elapsed = e_ff;
            mem_wdata.active  = e_ff < rd_data_ff.length;
            bytes_in = {q_ff, bytes_ff[BYTES_W-1:LEVEL_W]};
            addr_in  = addr_ff + 1'b1;
            state_in = S_FR_RD;
            if (idx[BYTE_SEL_W-1:0] == '1) begin
               addr_in  = addr_ff;
               state_in = S_EMIT;
            end
         end
         // hand one eight-channel chunk to the output register
         S_EMIT: begin
            if (can_emit) begin
               out_valid_in  = 1'b1;
               out_status_in = live_ff ? ST_DONE : ST_INACTIVE;
               out_uni_in    = op_ff.universe;
               out_chunk_in  = idx[IDX_W-1:BYTE_SEL_W];
               out_bytes_in  = live_ff ? bytes_ff : '0;
               out_last_in   = idx == '1;
               addr_in       = addr_ff + 1'b1;
               state_in      = (idx == '1) ? S_IDLE : S_FR_RD;
            end
         end
         S_RESP: begin
            if (can_emit) begin
               out_valid_in  = 1'b1;
               out_status_in = resp_status_ff;
               out_uni_in    = resp_uni_ff;
               out_chunk_in  = '0;
               out_bytes_in  = '0;
               out_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         addr_ff        <= '0;
         slot_active_ff <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         addr_ff        <= addr_in;
         slot_active_ff <= slot_active_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      advance_ff     <= advance_in;
      live_ff        <= live_in;
      resp_status_ff <= resp_status_in;
      resp_uni_ff    <= resp_uni_in;
      bytes_ff       <= bytes_in;
      e_ff           <= e_in;
      p1_ff          <= p1_in;
      p2_ff          <= p2_in;
      rem_ff         <= rem_in;
      q_ff           <= q_in;
      bit_ff         <= bit_in;
      out_status_ff  <= out_status_in;
      out_uni_ff     <= out_uni_in;
      out_chunk_ff   <= out_chunk_in;
      out_bytes_ff   <= out_bytes_in;
      out_last_ff    <= out_last_in;
   end

   // store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= mem_wdata;
      end
      rd_data_ff <= mem[addr_ff];
   end

endmodule

// ===== hw/rtl/dmx_channel_fade_engine.sv =====
// dmx_channel_fade_engine: top level of the DMX channel level and fade engine.
// Depends on dfe_pkg, dfe_chan_if, dfe_front, dfe_queue and dfe_back.
//
//   channel    direction  contents
//   req_chan   in         command, universe, channel, value, duration_ms
//   rsp_chan   out        status, universe_res, chunk_index, channel_bytes, last
//
// Set and fade run dispatch, store read, store write and response; ignored and unknown
// commands go from dispatch straight to the response. Blackout and fade-all sweep the
// 2048-entry store, reading then writing each entry. Tick and read walk 512 channels;
// a fading channel on a tick adds two multiplies, a sum and the 8-step divider. After
// reset a clearing pass zeroes all 2048 entries before the first command executes.
// Requests queue two deep; a stalled response stops the sequencer, not the queue.
module dmx_channel_fade_engine (
   input  logic     clock,
   input  logic     reset,
   dfe_req_if.sink  req_chan,
   dfe_rsp_if.source rsp_chan
);
   import dfe_pkg::*;

   op_type push_data;
   op_type pop_data;
   logic   push;
   logic   pop;
   logic   full;
   logic   empty;

   dfe_front u_front (
      .req_chan   (req_chan),
      .queue_full (full),
      .op_push    (push),
      .op_data    (push_data)
   );

   dfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (full),
      .empty     (empty)
   );

   dfe_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (!empty),
      .op_data  (pop_data),
      .op_pop   (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
